@@ rtl/itda_pkg.sv @@
`timescale 1ns / 1ps
package itda_pkg;

   localparam int ValueWidth = 64;
   localparam int DigitCount = 19;
   localparam int BcdWidth   = 4 * DigitCount;
   localparam int CharWidth  = 6;
   localparam int StepWidth  = $clog2(ValueWidth);
   localparam int RemWidth   = $clog2(DigitCount + 1);

   localparam logic [CharWidth-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CharWidth-1:0] CHAR_MINUS = 6'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_DABBLE,
      OP_DIGIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   emit_sign;
      logic   emit_digit;
      logic   last;
   } ctrl_type;

   typedef struct packed {
      logic       negative;
      logic [3:0] top_digit;
   } status_type;

endpackage

@@ rtl/itda_bcd_unit.sv @@
`timescale 1ns / 1ps
module itda_bcd_unit (
   input  logic                                 clock,
   input  itda_pkg::ctrl_type                   ctrl,
   input  logic signed [itda_pkg::ValueWidth-1:0] req_value,
   output itda_pkg::status_type                 status
);
   import itda_pkg::*;

   logic [ValueWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic                  neg_ff, neg_in;
   logic [BcdWidth-1:0]   adj;

   // add-3 correction on every digit before the shift
   always_comb begin
      logic [3:0] dig;
      dig = '0;
      for (int i = 0; i < DigitCount; i++) begin
         dig = bcd_ff[4*i +: 4];
         adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            neg_in = req_value[ValueWidth-1];
            bin_in = req_value[ValueWidth-1] ? (~req_value + 64'd1) : req_value;
            bcd_in = '0;
         end
         OP_DABBLE: begin
            {bcd_in, bin_in} = {adj[BcdWidth-2:0], bin_ff, 1'b0};
         end
         OP_DIGIT: begin
            bcd_in = {bcd_ff[BcdWidth-5:0], 4'd0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign status.negative  = neg_ff;
   assign status.top_digit = bcd_ff[BcdWidth-1 -: 4];

endmodule

@@ rtl/itda_seq.sv @@
`timescale 1ns / 1ps
module itda_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  itda_pkg::status_type status,
   output logic                 busy,
   output itda_pkg::ctrl_type   ctrl
);
   import itda_pkg::*;

   localparam logic [StepWidth-1:0] LastStep  = StepWidth'(ValueWidth - 1);
   localparam logic [RemWidth-1:0]  AllDigits = RemWidth'(DigitCount);
   localparam logic [StepWidth-1:0] StepOne   = StepWidth'(1);
   localparam logic [RemWidth-1:0]  RemOne    = RemWidth'(1);

   state_type            state_ff, state_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [RemWidth-1:0]  rem_ff, rem_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rem_ff   <= rem_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      rem_in          = rem_ff;
      ctrl.op         = OP_HOLD;
      ctrl.emit_sign  = 1'b0;
      ctrl.emit_digit = 1'b0;
      ctrl.last       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.op  = OP_LOAD;
               step_in  = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.op        = OP_DABBLE;
            ctrl.emit_sign = (step_ff == '0) && status.negative;
            step_in        = step_ff + StepOne;
            if (step_ff == LastStep) begin
               rem_in   = AllDigits;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (status.top_digit == 4'd0 && rem_ff != RemOne) begin
               ctrl.op = OP_DIGIT;
               rem_in  = rem_ff - RemOne;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            ctrl.op         = OP_DIGIT;
            ctrl.emit_digit = 1'b1;
            ctrl.last       = (rem_ff == RemOne);
            rem_in          = rem_ff - RemOne;
            if (rem_ff == RemOne) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ rtl/int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// Channel    Transfer when        Ports
// request    start && !busy       req_value[63:0] (signed)
// response   rsp_valid            rsp_ascii_char[5:0], rsp_last
//
// A number takes one double-dabble step per input bit on the shared BCD
// shifter, then drops leading zeros, leaves the skip state and sends the
// digits: busy stays high equally long after the transfer for any value.
// A minus sign goes out during the conversion; the last digit shows in the
// same cycle that busy falls. Results are registered and shown for one cycle
// each; the receiver cannot stall. Synchronous reset returns to idle.
module int_to_decimal_ascii (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [itda_pkg::ValueWidth-1:0]  req_value,
   output logic                                    rsp_valid,
   output logic [itda_pkg::CharWidth-1:0]          rsp_ascii_char,
   output logic                                    rsp_last
);
   import itda_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0] rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   itda_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   itda_bcd_unit u_bcd (
      .clock     (clock),
      .ctrl      (ctrl),
      .req_value (req_value),
      .status    (status)
   );

   always_comb begin
      rsp_valid_in = ctrl.emit_sign | ctrl.emit_digit;
      rsp_char_in  = ctrl.emit_sign ? CHAR_MINUS : CHAR_ZERO + {2'b00, status.top_digit};
      rsp_last_in  = ctrl.emit_digit & ctrl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer did not start conversion");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last character while still busy");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii_char == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign marked last");

   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |=> rsp_valid == $past(req_value[ValueWidth-1], 2))
      else $error("minus sign missing or spurious");

endmodule
